// File: rtl/core/lfu_pkg.sv
// Package: shared constants, status codes and control bundles for the LFU cache.
`default_nettype none
package lfu_pkg;
    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 64;
    localparam int KEY_W          = 32;
    localparam int COUNT_W        = 32;
    localparam int CFG_W          = 5;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    localparam logic [CFG_W-1:0]   CAP_RESET = 5'd16;
    localparam logic [APB_AW-1:0]  ADDR_CAP  = 3'd0;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_ONE = 32'd1;

    localparam logic [1:0] ST_SET_NEW  = 2'd0;
    localparam logic [1:0] ST_SET_UPD  = 2'd1;
    localparam logic [1:0] ST_GET_HIT  = 2'd2;
    localparam logic [1:0] ST_GET_MISS = 2'd3;

    localparam logic KIND_SET = 1'b1;

    typedef struct packed {
        logic accept;
        logic srch_rd;
        logic srch_cmp;
        logic ev_rd;
        logic ev_ld;
        logic sd_rd;
        logic sd_cmp;
        logic append;
        logic su_rd;
        logic su_cmp;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic srch_end;
        logic match;
        logic full;
        logic need_append;
        logic sd_move;
        logic su_top;
        logic su_move;
        logic out_free;
    } t_stat;
endpackage
`default_nettype wire

// File: rtl/core/lfu_ctrl.sv
// Controller: sequences search, eviction, sift down, append and sift up per request.
`default_nettype none
module lfu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output lfu_pkg::t_cmd      o_cmd,
    input  wire lfu_pkg::t_stat i_stat
);
    import lfu_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SRCH_RD  = 4'd1;
    localparam logic [3:0] S_SRCH_CMP = 4'd2;
    localparam logic [3:0] S_EV_RD    = 4'd3;
    localparam logic [3:0] S_EV_LD    = 4'd4;
    localparam logic [3:0] S_SD_RD    = 4'd5;
    localparam logic [3:0] S_SD_CMP   = 4'd6;
    localparam logic [3:0] S_APPEND   = 4'd7;
    localparam logic [3:0] S_SU_RD    = 4'd8;
    localparam logic [3:0] S_SU_CMP   = 4'd9;
    localparam logic [3:0] S_FINISH   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (i_stat.srch_end) begin
                    if (i_stat.need_append) begin
                        n_state = i_stat.full ? S_EV_RD : S_APPEND;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    o_cmd.srch_rd = 1'b1;
                    n_state       = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                o_cmd.srch_cmp = 1'b1;
                n_state        = i_stat.match ? S_SD_RD : S_SRCH_RD;
            end
            S_EV_RD: begin
                o_cmd.ev_rd = 1'b1;
                n_state     = S_EV_LD;
            end
            S_EV_LD: begin
                o_cmd.ev_ld = 1'b1;
                n_state     = S_SD_RD;
            end
            S_SD_RD: begin
                o_cmd.sd_rd = 1'b1;
                n_state     = S_SD_CMP;
            end
            S_SD_CMP: begin
                o_cmd.sd_cmp = 1'b1;
                if (i_stat.sd_move) begin
                    n_state = S_SD_RD;
                end else begin
                    n_state = i_stat.need_append ? S_APPEND : S_FINISH;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_SU_RD;
            end
            S_SU_RD: begin
                o_cmd.su_rd = 1'b1;
                n_state     = i_stat.su_top ? S_FINISH : S_SU_CMP;
            end
            S_SU_CMP: begin
                o_cmd.su_cmp = 1'b1;
                n_state      = i_stat.su_move ? S_SU_RD : S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
endmodule
`default_nettype wire

// File: rtl/core/lfu_dp.sv
// Datapath: heap memories, search index, moving entry, fill count and result register.
`default_nettype none
module lfu_dp #(
    parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = lfu_pkg::VALUE_BITS_DEF,
    localparam int IDX_W     = $clog2(CAPACITY),
    localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire lfu_pkg::t_cmd               i_cmd,
    output lfu_pkg::t_stat                   o_stat,
    input  wire logic [CNT_W-1:0]            i_cap,
    input  wire logic                        i_kind,
    input  wire logic [lfu_pkg::KEY_W-1:0]   i_key,
    input  wire logic [VALUE_BITS-1:0]       i_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [1:0]                       o_status,
    output logic [VALUE_BITS-1:0]            o_read_value,
    output logic                             o_evicted,
    output logic [lfu_pkg::KEY_W-1:0]        o_evicted_key
);
    import lfu_pkg::*;

    localparam int EW = CNT_W + 1;

    logic [KEY_W-1:0]      mem_key [CAPACITY];
    logic [VALUE_BITS-1:0] mem_val [CAPACITY];
    logic [COUNT_W-1:0]    mem_cnt [CAPACITY];

    logic [CNT_W-1:0]      r_n, r_idx, r_pos;
    logic                  r_kind, r_hit, r_ev, r_out_valid;
    logic [KEY_W-1:0]      r_key, r_evkey, r_cur_key, r_a_key, r_b_key;
    logic [VALUE_BITS-1:0] r_val, r_rdval, r_cur_val, r_a_val, r_b_val;
    logic [COUNT_W-1:0]    r_cur_cnt, r_a_cnt, r_b_cnt;
    logic [1:0]            r_o_status;
    logic [VALUE_BITS-1:0] r_o_rdval;
    logic                  r_o_ev;
    logic [KEY_W-1:0]      r_o_evkey;

    logic [EW-1:0]         l_ext, rt_ext, n_ext;
    logic [CNT_W-1:0]      par, n_m1;
    logic                  l_ok, rt_ok, go_left, go_right;
    logic [COUNT_W-1:0]    best_cnt;
    logic [IDX_W-1:0]      ra, rb, wa;
    logic                  we;
    logic [KEY_W-1:0]      wk;
    logic [VALUE_BITS-1:0] wv;
    logic [COUNT_W-1:0]    wc;

    assign n_ext    = EW'(r_n);
    assign l_ext    = (EW'(r_pos) << 1) + EW'(1);
    assign rt_ext   = l_ext + EW'(1);
    assign par      = (r_pos - CNT_W'(1)) >> 1;
    assign n_m1     = r_n - CNT_W'(1);
    assign l_ok     = l_ext < n_ext;
    assign rt_ok    = rt_ext < n_ext;
    assign go_left  = l_ok && (r_a_cnt < r_cur_cnt);
    assign best_cnt = go_left ? r_a_cnt : r_cur_cnt;
    assign go_right = rt_ok && (r_b_cnt < best_cnt);

    always_comb begin
        o_stat.srch_end    = (r_idx == r_n);
        o_stat.match       = (r_a_key == r_key);
        o_stat.full        = (r_n >= i_cap) && (r_n != '0);
        o_stat.need_append = (r_kind == KIND_SET) && !r_hit;
        o_stat.sd_move     = go_left || go_right;
        o_stat.su_top      = (r_pos == '0);
        o_stat.su_move     = (r_a_cnt > r_cur_cnt);
        o_stat.out_free    = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        ra = '0;
        rb = '0;
        if (i_cmd.srch_rd) begin
            ra = r_idx[IDX_W-1:0];
        end else if (i_cmd.ev_rd) begin
            rb = n_m1[IDX_W-1:0];
        end else if (i_cmd.sd_rd) begin
            ra = l_ext[IDX_W-1:0];
            rb = rt_ext[IDX_W-1:0];
        end else if (i_cmd.su_rd) begin
            ra = par[IDX_W-1:0];
        end
    end

    always_comb begin
        we = 1'b0;
        wa = r_pos[IDX_W-1:0];
        wk = r_cur_key;
        wv = r_cur_val;
        wc = r_cur_cnt;
        if (i_cmd.sd_cmp) begin
            we = 1'b1;
            if (go_right) begin
                wk = r_b_key;
                wv = r_b_val;
                wc = r_b_cnt;
            end else if (go_left) begin
                wk = r_a_key;
                wv = r_a_val;
                wc = r_a_cnt;
            end
        end else if (i_cmd.su_rd) begin
            we = o_stat.su_top;
        end else if (i_cmd.su_cmp) begin
            we = 1'b1;
            if (o_stat.su_move) begin
                wk = r_a_key;
                wv = r_a_val;
                wc = r_a_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_key[wa] <= wk;
            mem_val[wa] <= wv;
            mem_cnt[wa] <= wc;
        end
        r_a_key <= mem_key[ra];
        r_a_val <= mem_val[ra];
        r_a_cnt <= mem_cnt[ra];
        r_b_key <= mem_key[rb];
        r_b_val <= mem_val[rb];
        r_b_cnt <= mem_cnt[rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ev_ld) begin
                r_n <= n_m1;
            end else if (i_cmd.append) begin
                r_n <= r_n + CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_kind;
            r_key   <= i_key;
            r_val   <= i_value;
            r_idx   <= '0;
            r_hit   <= 1'b0;
            r_ev    <= 1'b0;
            r_evkey <= '0;
            r_rdval <= '0;
        end
        if (i_cmd.srch_cmp) begin
            if (o_stat.match) begin
                r_hit     <= 1'b1;
                r_pos     <= r_idx;
                r_cur_key <= r_a_key;
                r_cur_val <= (r_kind == KIND_SET) ? r_val : r_a_val;
                r_cur_cnt <= (r_a_cnt == COUNT_MAX) ? r_a_cnt : r_a_cnt + COUNT_ONE;
                r_rdval   <= r_a_val;
            end else begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
        if (i_cmd.ev_ld) begin
            r_ev      <= 1'b1;
            r_evkey   <= r_a_key;
            r_cur_key <= r_b_key;
            r_cur_val <= r_b_val;
            r_cur_cnt <= r_b_cnt;
            r_pos     <= '0;
        end
        if (i_cmd.sd_cmp && o_stat.sd_move) begin
            r_pos <= go_right ? rt_ext[CNT_W-1:0] : l_ext[CNT_W-1:0];
        end
        if (i_cmd.append) begin
            r_cur_key <= r_key;
            r_cur_val <= r_val;
            r_cur_cnt <= COUNT_ONE;
            r_pos     <= r_n;
        end
        if (i_cmd.su_cmp && o_stat.su_move) begin
            r_pos <= par;
        end
        if (i_cmd.out_load) begin
            if (r_kind == KIND_SET) begin
                r_o_status <= r_hit ? ST_SET_UPD : ST_SET_NEW;
                r_o_rdval  <= '0;
            end else begin
                r_o_status <= r_hit ? ST_GET_HIT : ST_GET_MISS;
                r_o_rdval  <= r_hit ? r_rdval : '0;
            end
            r_o_ev    <= r_ev;
            r_o_evkey <= r_evkey;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_read_value  = r_o_rdval;
    assign o_evicted     = r_o_ev;
    assign o_evicted_key = r_o_evkey;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");
    a_evict_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_ev) |-> (r_o_status == ST_SET_NEW))
        else $error("eviction reported on a request that did not insert");
    a_value_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_o_status != ST_GET_HIT)) |-> (r_o_rdval == '0))
        else $error("read value set without a get hit");
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |=> (r_n == $past(r_n) + CNT_W'(1)))
        else $error("append did not grow the fill");
endmodule
`default_nettype wire

// File: rtl/core/lfu_cache_min_heap.sv
// Top level: LFU cache held as a binary min-heap with an APB capacity register.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+----------------------------------------
//  request   | i_in_valid / o_in_stall  | i_kind, i_key, i_value
//  result    | o_out_valid / i_out_stall| o_status, o_read_value, o_evicted,
//            |                          | o_evicted_key
//  config    | psel/penable/pwrite      | paddr, pwdata, prdata, pready
//
//  One request at a time: accepted from idle, then the work, then a finish state.
//  Key search reads then compares one slot at a time; a miss scans all n entries.
//  Each sift level reads then compares; sift down runs after a hit or an eviction;
//  append is followed by sift up; eviction first moves the last entry to the root.
//  A stalled result holds the next request at finish.
//  Synchronous active-low reset empties the cache and sets capacity to 16.
`default_nettype none
module lfu_cache_min_heap #(
    parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = lfu_pkg::VALUE_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_kind,
    input  wire logic [lfu_pkg::KEY_W-1:0]   i_key,
    input  wire logic [VALUE_BITS-1:0]       i_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [1:0]                       o_status,
    output logic [VALUE_BITS-1:0]            o_read_value,
    output logic                             o_evicted,
    output logic [lfu_pkg::KEY_W-1:0]        o_evicted_key,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lfu_pkg::APB_AW-1:0]  paddr,
    input  wire logic [lfu_pkg::APB_DW-1:0]  pwdata,
    output logic [lfu_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);
    import lfu_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0] r_cap;
    logic [CW-1:0]    cap_ext;
    logic [CNT_W-1:0] cap_live;
    t_cmd             cmd;
    t_stat            stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_CAP)) begin
            r_cap <= pwdata[CFG_W-1:0];
        end
    end

    assign pready  = 1'b1;
    assign prdata  = (paddr == ADDR_CAP) ? APB_DW'(r_cap) : '0;
    assign cap_ext = CW'(r_cap);

    always_comb begin
        if (cap_ext == '0) begin
            cap_live = CNT_W'(1);
        end else if (cap_ext > CW'(CAPACITY)) begin
            cap_live = CNT_W'(CAPACITY);
        end else begin
            cap_live = cap_ext[CNT_W-1:0];
        end
    end

    lfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    lfu_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cap         (cap_live),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );
endmodule
`default_nettype wire
